// ----- rtl/rmv_pkg.sv -----
// Shared types and constants for the running mean / variance block.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int MAX_COUNT = 65536;
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int MAG_W     = SAMPLE_W + 1;        // |sample - mean| magnitude
  localparam int M2_W      = 2 * SAMPLE_W - 1;    // Q31.32, saturating at 2^63-1
  localparam int PROD_W    = 2 * MAG_W;
  localparam int DIVD_W    = 2 * SAMPLE_W;
  localparam int STEP_W    = $clog2(DIVD_W + 1);
  localparam int IQ_DEPTH  = 2;
  localparam int IQ_AW     = $clog2(IQ_DEPTH);
  localparam int IQ_CW     = $clog2(IQ_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [M2_W-1:0]     variance;
    logic                overflow;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIVD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/rmv_front.sv -----
// Input side: small request queue that accepts samples and hands them to the back end.
// Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmv_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [rmv_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic          last_sample_i,
  output logic               item_valid_o,
  output rmv_pkg::item_t     item_o,
  input  wire logic          item_pop_i
);

  rmv_pkg::item_t                   mem_q [rmv_pkg::IQ_DEPTH];
  logic [rmv_pkg::IQ_AW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [rmv_pkg::IQ_CW-1:0]        count_q;
  logic                             do_push, do_pop;

  assign full         = (count_q == rmv_pkg::IQ_CW'(rmv_pkg::IQ_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= '{sample: sample_i, last: last_sample_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == rmv_pkg::IQ_AW'(rmv_pkg::IQ_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == rmv_pkg::IQ_AW'(rmv_pkg::IQ_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rmv_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, step count set per request.
// Depends on rmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmv_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rmv_pkg::div_req_t req_i,
  output rmv_pkg::div_rsp_t rsp_o
);

  logic [rmv_pkg::DIVD_W-1:0] dvd_q;   // dividend shifts out the top, quotient in the bottom
  logic [rmv_pkg::CNT_W-1:0]  dsr_q;
  logic [rmv_pkg::CNT_W-1:0]  rem_q;
  logic [rmv_pkg::STEP_W-1:0] cnt_q;
  logic                       busy_q, done_q;

  logic [rmv_pkg::CNT_W:0]    shifted, diff;
  logic                       ge;

  assign shifted = {rem_q, dvd_q[rmv_pkg::DIVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = (shifted >= {1'b0, dsr_q});

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      // pulse after the last step
      done_q <= !req_i.start && busy_q && (cnt_q == rmv_pkg::STEP_W'(1));
      if (req_i.start) begin
        dvd_q  <= req_i.dividend;
        dsr_q  <= req_i.divisor;
        rem_q  <= '0;
        cnt_q  <= req_i.steps;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[rmv_pkg::DIVD_W-2:0], ge};
        rem_q <= ge ? diff[rmv_pkg::CNT_W-1:0] : shifted[rmv_pkg::CNT_W-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rmv_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rmv_back.sv -----
// Back end: sequencer that folds one sample into mean / M2 and produces the final result.
// Depends on rmv_pkg; drives the shared divider rmv_div.
`timescale 1ns / 1ps
`default_nettype none

module rmv_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire rmv_pkg::item_t item_i,
  output logic                item_pop_o,
  output rmv_pkg::div_req_t   div_req_o,
  input  wire rmv_pkg::div_rsp_t div_rsp_i,
  output logic                res_valid_o,
  output rmv_pkg::result_t    res_o,
  input  wire logic           res_ready_i
);

  localparam int W  = rmv_pkg::SAMPLE_W;
  localparam int MW = rmv_pkg::MAG_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DELTA, ST_DIV_WAIT, ST_NEWMEAN, ST_MULT, ST_PROD,
    ST_ACCUM, ST_FINISH, ST_VAR_WAIT, ST_EMIT
  } state_e;

  state_e                      state_q;
  logic [W-1:0]                mean_q, nm_q, x_q;
  logic [rmv_pkg::M2_W-1:0]    m2_q, var_q;
  logic [rmv_pkg::CNT_W-1:0]   cnt_q;
  logic                        ovf_q, last_q, d0_neg_q;
  logic [MW-1:0]               d0mag_q, d1mag_q;
  logic [2*W-1:0]              pp_q;
  logic [rmv_pkg::PROD_W-1:0]  prod_q;

  logic [MW-1:0]               d0, d1;
  logic [MW:0]                 nm_ext, q_ext;
  logic [W-1:0]                nm_clamp;
  logic [rmv_pkg::PROD_W-1:0]  prod_sum;
  logic [rmv_pkg::M2_W:0]      m2_sum;
  logic                        prod_sat;

  assign item_pop_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = '{mean: mean_q, variance: var_q, overflow: ovf_q};

  assign d0 = {x_q[W-1], x_q} - {mean_q[W-1], mean_q};
  assign d1 = {x_q[W-1], x_q} - {nm_q[W-1], nm_q};

  // new mean = old mean +/- truncated quotient, clamped to Q16.16
  assign q_ext  = {1'b0, div_rsp_i.quotient[MW-1:0]};
  assign nm_ext = d0_neg_q ? ({{2{mean_q[W-1]}}, mean_q} - q_ext)
                           : ({{2{mean_q[W-1]}}, mean_q} + q_ext);
  always_comb begin
    if (!nm_ext[MW] && (nm_ext[MW-1:W-1] != 2'b00)) begin
      nm_clamp = {1'b0, {(W-1){1'b1}}};
    end else if (nm_ext[MW] && (nm_ext[MW-1:W-1] != 2'b11)) begin
      nm_clamp = {1'b1, {(W-1){1'b0}}};
    end else begin
      nm_clamp = nm_ext[W-1:0];
    end
  end

  // 33x33 product from one 32x32 partial plus shifted corrections for the top bits
  assign prod_sum = rmv_pkg::PROD_W'(pp_q)
                  + (d0mag_q[W] ? rmv_pkg::PROD_W'({d1mag_q[W-1:0], {W{1'b0}}}) : '0)
                  + (d1mag_q[W] ? rmv_pkg::PROD_W'({d0mag_q[W-1:0], {W{1'b0}}}) : '0)
                  + ((d0mag_q[W] && d1mag_q[W]) ? {2'b01, {(2*W){1'b0}}} : '0);

  assign prod_sat = |prod_q[rmv_pkg::PROD_W-1:rmv_pkg::M2_W];
  assign m2_sum   = {1'b0, m2_q} + {1'b0, prod_q[rmv_pkg::M2_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mean_q    <= '0;
      m2_q      <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      var_q     <= '0;
      nm_q      <= '0;
      x_q       <= '0;
      last_q    <= 1'b0;
      d0_neg_q  <= 1'b0;
      d0mag_q   <= '0;
      d1mag_q   <= '0;
      pp_q      <= '0;
      prod_q    <= '0;
      div_req_o <= '0;
    end else begin
      // one-cycle start for the mean step and for the final variance division
      div_req_o.start <= (state_q == ST_DELTA) || ((state_q == ST_FINISH) && last_q);
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            x_q    <= item_i.sample;
            last_q <= item_i.last;
            if (cnt_q >= rmv_pkg::CNT_W'(rmv_pkg::MAX_COUNT)) begin
              ovf_q   <= 1'b1;
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_DELTA;
            end
          end
        end
        ST_DELTA: begin
          d0_neg_q           <= d0[MW-1];
          d0mag_q            <= d0[MW-1] ? (~d0 + 1'b1) : d0;
          div_req_o.steps    <= rmv_pkg::STEP_W'(MW);
          div_req_o.dividend <= {(d0[MW-1] ? (~d0 + 1'b1) : d0),
                                 {(rmv_pkg::DIVD_W-MW){1'b0}}};
          div_req_o.divisor  <= cnt_q + 1'b1;
          state_q            <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp_i.done) begin
            nm_q    <= nm_clamp;
            state_q <= ST_NEWMEAN;
          end
        end
        ST_NEWMEAN: begin
          d1mag_q <= d1[MW-1] ? (~d1 + 1'b1) : d1;
          state_q <= ST_MULT;
        end
        ST_MULT: begin
          pp_q    <= d0mag_q[W-1:0] * d1mag_q[W-1:0];
          state_q <= ST_PROD;
        end
        ST_PROD: begin
          prod_q  <= prod_sum;
          state_q <= ST_ACCUM;
        end
        ST_ACCUM: begin
          if (prod_sat || m2_sum[rmv_pkg::M2_W]) begin
            m2_q  <= '1;
            ovf_q <= 1'b1;
          end else begin
            m2_q <= m2_sum[rmv_pkg::M2_W-1:0];
          end
          mean_q  <= nm_q;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (last_q) begin
            div_req_o.steps    <= rmv_pkg::STEP_W'(rmv_pkg::DIVD_W);
            div_req_o.dividend <= {1'b0, m2_q};
            // single sample: variance is M2 itself
            div_req_o.divisor  <= (cnt_q > rmv_pkg::CNT_W'(1)) ? (cnt_q - 1'b1)
                                                               : rmv_pkg::CNT_W'(1);
            state_q            <= ST_VAR_WAIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_VAR_WAIT: begin
          if (div_rsp_i.done) begin
            var_q   <= div_rsp_i.quotient[rmv_pkg::M2_W-1:0];
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (res_ready_i) begin
            mean_q  <= '0;
            m2_q    <= '0;
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/running_mean_variance.sv -----
// Running mean and sample variance (Welford) over signed Q16.16 samples.
// Input channel: push / full, sample_i and last_sample_i; a request is taken when
//   push is high and full is low. A two-entry queue buffers requests.
// Result channel: empty / pop; mean_value_o, variance_value_o and count_overflow_o
//   hold the oldest result while empty is low; pop takes it.
// One result appears per sequence, after the sample marked with last_sample_i.
// A plain sample occupies the back end through a 33-step radix-2 division of
//   (sample - mean) by the count in rmv_div; the next sample is taken only once
//   the back end is idle again. A sample past the count limit skips that division.
// A marked sample then runs a 64-step division of M2 by (n - 1) in the same
//   divider, and its result passes on through the output register.
// When the receiver does not pop, the result register stays full, the back end
//   holds its finished result, and the input queue fills and raises full.
// Reset clears the queues, the running statistics and the sample count; the
//   block accepts requests in the first cycle after reset.
// Depends on rmv_pkg, rmv_front, rmv_div and rmv_back.
`timescale 1ns / 1ps
`default_nettype none

module running_mean_variance (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [rmv_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                         last_sample_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [rmv_pkg::SAMPLE_W-1:0]      mean_value_o,
  output logic [rmv_pkg::M2_W-1:0]          variance_value_o,
  output logic                              count_overflow_o
);

  logic               item_valid, item_pop;
  rmv_pkg::item_t     item;
  rmv_pkg::div_req_t  div_req;
  rmv_pkg::div_rsp_t  div_rsp;
  logic               res_valid, res_ready;
  rmv_pkg::result_t   res;
  rmv_pkg::result_t   out_q;
  logic               out_valid_q;

  rmv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  rmv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rmv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  assign res_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign empty            = !out_valid_q;
  assign mean_value_o     = out_q.mean;
  assign variance_value_o = out_q.variance;
  assign count_overflow_o = out_q.overflow;

endmodule

`default_nettype wire

// ----- tb/running_mean_variance_tb.sv -----
// Self-checking testbench for running_mean_variance: Welford mean / variance.
// Directed table, then random request sequences, checked against a local predictor.
// Depends on rmv_pkg and the running_mean_variance RTL.
`timescale 1ns / 1ps

module running_mean_variance_tb;

  localparam logic [63:0] M2_CAP   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          HOLD_CYC = 800;    // long receiver hold-off
  localparam int          QUIET_MAX = 6000;  // watchdog: cycles with no request or result moved
  localparam int          TAIL_CYC = 150;    // > marked-sample latency
  localparam int          RAND_PER_MODE = 200;
  localparam int          DIR_N = 22;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct packed {
    logic [rmv_pkg::SAMPLE_W-1:0] smp;
    logic                         mark;
    logic                         typed;
    rmv_pkg::result_t             want;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         push = 1'b0;
  logic                         full;
  logic [rmv_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic                         last_sample_i = 1'b0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [rmv_pkg::SAMPLE_W-1:0] mean_value_o;
  logic [rmv_pkg::M2_W-1:0]     variance_value_o;
  logic                         count_overflow_o;

  running_mean_variance u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .sample_i         (sample_i),
    .last_sample_i    (last_sample_i),
    .empty            (empty),
    .pop              (pop),
    .mean_value_o     (mean_value_o),
    .variance_value_o (variance_value_o),
    .count_overflow_o (count_overflow_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Predictor state
  logic signed [rmv_pkg::SAMPLE_W-1:0] run_mean = '0;
  logic [63:0]                         run_m2 = '0;
  int unsigned                         run_count = 0;
  bit                                  run_ovf = 1'b0;

  rmv_pkg::result_t results_due[$];
  rmv_pkg::result_t head_res;
  int unsigned      err_cnt = 0;
  int unsigned      send_pct = 0;
  int unsigned      stall_pct = 0;
  bit               hold_req = 1'b0;

  // Folds one sample into the running statistics; returns 1 when a result is due.
  function automatic bit fold_sample(input logic [rmv_pkg::SAMPLE_W-1:0] smp, input bit mk,
                                     output rmv_pkg::result_t res);
    logic signed [rmv_pkg::SAMPLE_W-1:0] x;
    longint      d0, d1, nm;
    logic [63:0] ad0, ad1, q, inc, var_q;
    logic [127:0] prod;
    int unsigned n;
    bit          sat;
    x = smp;
    sat = 1'b0;
    res = '0;
    if (run_count >= rmv_pkg::MAX_COUNT) begin
      run_ovf = 1'b1;
    end else begin
      n = run_count + 1;
      d0 = longint'(x) - longint'(run_mean);
      ad0 = (d0 < 0) ? -d0 : d0;
      q = ad0 / n;
      nm = (d0 < 0) ? longint'(run_mean) - longint'(q) : longint'(run_mean) + longint'(q);
      if (nm > 64'sd2147483647) nm = 64'sd2147483647;
      if (nm < -64'sd2147483648) nm = -64'sd2147483648;
      d1 = longint'(x) - nm;
      ad1 = (d1 < 0) ? -d1 : d1;
      prod = {64'd0, ad0} * {64'd0, ad1};
      if (prod > {64'd0, M2_CAP}) begin
        inc = M2_CAP;
        sat = 1'b1;
      end else begin
        inc = prod[63:0];
      end
      if (inc > M2_CAP - run_m2) begin
        run_m2 = M2_CAP;
        sat = 1'b1;
      end else begin
        run_m2 = run_m2 + inc;
      end
      if (sat) run_ovf = 1'b1;
      run_mean = nm[rmv_pkg::SAMPLE_W-1:0];
      run_count = n;
    end
    if (!mk) return 1'b0;
    var_q = run_m2;
    if (run_count > 1) var_q = run_m2 / (run_count - 1);
    res.mean = run_mean;
    res.variance = var_q[rmv_pkg::M2_W-1:0];
    res.overflow = run_ovf;
    run_mean = '0;
    run_m2 = '0;
    run_count = 0;
    run_ovf = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [rmv_pkg::SAMPLE_W-1:0] pick_sample(
      input int style, input logic [rmv_pkg::SAMPLE_W-1:0] prev);
    logic [rmv_pkg::SAMPLE_W-1:0] v;
    case (style)
      0: v = $urandom;
      1: begin
        case ($urandom_range(3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      2: v = $urandom_range(32'h000F_FFFF) - 32'h0008_0000;   // within +/-8.0
      3: v = prev + $urandom_range(32'h3FFF) - 32'h2000;       // random walk
      default: v = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF);
    endcase
    return v;
  endfunction

  task automatic set_idle(input idle_e m);
    send_pct  = (m == IDLE_SEND) ? 56 : (m == IDLE_BOTH) ? 17 : 0;
    stall_pct = (m == IDLE_RECV) ? 56 : (m == IDLE_BOTH) ? 17 : 0;
  endtask

  // Offers one request and waits for it to be taken; a typed row replaces the prediction.
  task automatic send_item(input logic [rmv_pkg::SAMPLE_W-1:0] smp, input bit mk,
                           input bit typed, input rmv_pkg::result_t want);
    rmv_pkg::result_t res;
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    sample_i <= smp;
    last_sample_i <= mk;
    do @(posedge clk_i); while (full);
    if (fold_sample(smp, mk, res))
      results_due.insert(results_due.size(), typed ? want : res);
  endtask

  task automatic send_seq(input int len);
    int style;
    logic [rmv_pkg::SAMPLE_W-1:0] prev, x;
    style = $urandom_range(4);
    prev = pick_sample(2, '0);
    for (int i = 0; i < len; i++) begin
      x = pick_sample(style, prev);
      send_item(x, i == len - 1, 1'b0, '0);
      prev = x;
    end
  endtask

  task automatic wait_results_done();
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  dir_row_t dir_tab [DIR_N] = '{
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 63'd0, 1'b0}},
    '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 63'd0, 1'b0}},
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 63'd0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 63'd0, 1'b0}},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b1, 1'b0, '0},
    // full-scale swings: M2 saturates on the third sample
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, '0},
    '{32'h0001_0000, 1'b0, 1'b0, '0},
    '{32'h0001_0000, 1'b0, 1'b0, '0},
    '{32'h0001_0000, 1'b0, 1'b0, '0},
    '{32'h0001_0000, 1'b1, 1'b1, '{32'h0001_0000, 63'd0, 1'b0}},
    '{32'h0001_0000, 1'b0, 1'b0, '0},
    '{32'h0003_0000, 1'b1, 1'b0, '0},
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0, '0},
    '{32'hFFFF_0000, 1'b0, 1'b0, '0},
    '{32'hFFFE_0000, 1'b0, 1'b0, '0},
    '{32'hFFFD_0000, 1'b1, 1'b0, '0}
  };

  // Receiver: random stalls, plus one long hold-off on request from the sender.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: mean %h variance %h overflow %b",
               mean_value_o, variance_value_o, count_overflow_o);
        err_cnt++;
      end else begin
        head_res = results_due.pop_front();
        if (mean_value_o !== head_res.mean) begin
          $error("mean_value: expected %h, got %h", head_res.mean, mean_value_o);
          err_cnt++;
        end
        if (variance_value_o !== head_res.variance) begin
          $error("variance_value: expected %h, got %h", head_res.variance, variance_value_o);
          err_cnt++;
        end
        if (count_overflow_o !== head_res.overflow) begin
          $error("count_overflow: expected %b, got %b", head_res.overflow, count_overflow_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("running_mean_variance_tb: done, errors");
    $finish;
  end

  initial begin
    int sent;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idle(IDLE_NONE);
    for (int i = 0; i < DIR_N; i++)
      send_item(dir_tab[i].smp, dir_tab[i].mark, dir_tab[i].typed, dir_tab[i].want);

    // Back up results while the receiver holds off, so full rises.
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_seq($urandom_range(1, 2));
    @(negedge clk_i);
    push <= 1'b0;
    wait_results_done();

    for (int m = 0; m < 4; m++) begin
      set_idle(idle_e'(m));
      sent = 0;
      while (sent < RAND_PER_MODE) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
        send_seq(len);
        sent += len;
      end
    end

    set_idle(IDLE_NONE);
    @(negedge clk_i);
    push <= 1'b0;
    wait_results_done();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (err_cnt == 0)
      $display("running_mean_variance_tb: done, clean");
    else
      $display("running_mean_variance_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rmv_pkg.sv
rtl/rmv_front.sv
rtl/rmv_div.sv
rtl/rmv_back.sv
rtl/running_mean_variance.sv
tb/running_mean_variance_tb.sv
